/* rtl/core/kpq_pkg.sv */
// Shared types and constants for the keypad press qualifier.
`timescale 1ns / 1ps

package kpq_pkg;

  localparam int unsigned NumButtons = 8;

  // Qualifier phase of one button.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_HELD    = 2'd2,
    PH_HOLDOFF = 2'd3
  } phase_e;

  // Direction change event.
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_NEW  = 2'd1,
    EV_SAME = 2'd2
  } dir_event_e;

  // Eight-way direction codes, clockwise from up.
  localparam logic signed [3:0] DirNone      = -4'sd1;
  localparam logic signed [3:0] DirUp        = 4'sd0;
  localparam logic signed [3:0] DirUpRight   = 4'sd1;
  localparam logic signed [3:0] DirRight     = 4'sd2;
  localparam logic signed [3:0] DirDownRight = 4'sd3;
  localparam logic signed [3:0] DirDown      = 4'sd4;
  localparam logic signed [3:0] DirDownLeft  = 4'sd5;
  localparam logic signed [3:0] DirLeft      = 4'sd6;
  localparam logic signed [3:0] DirUpLeft    = 4'sd7;

  typedef struct packed {
    logic [7:0] button_keys;
    logic [3:0] direction_keys;
    logic       enter_key;
    logic       alt_fire_key;
    logic       escape_key;
  } in_t;

  typedef struct packed {
    logic [6:0]        virtual_buttons;
    logic signed [3:0] direction_code;
    logic [1:0]        direction_event;
    logic              quit_request;
  } out_t;

  // Result of the direction stage for one transaction.
  typedef struct packed {
    logic signed [3:0] code;
    dir_event_e        event_kind;
  } dir_res_t;

endpackage

/* rtl/core/kpq_qualifier.sv */
// Eight parallel press qualifiers, one per button.
`timescale 1ns / 1ps

module kpq_qualifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic [kpq_pkg::NumButtons-1:0]   keys_i,
  output logic [kpq_pkg::NumButtons-1:0]   press_o
);

  kpq_pkg::phase_e phase_q [kpq_pkg::NumButtons];
  kpq_pkg::phase_e phase_d [kpq_pkg::NumButtons];
  logic [kpq_pkg::NumButtons-1:0] tick_q;
  logic [kpq_pkg::NumButtons-1:0] tick_d;

  for (genvar n = 0; n < kpq_pkg::NumButtons; n++) begin : g_btn
    always_comb begin
      phase_d[n] = phase_q[n];
      tick_d[n]  = tick_q[n];
      case (phase_q[n])
        kpq_pkg::PH_IDLE: begin
          if (keys_i[n]) begin
            phase_d[n] = kpq_pkg::PH_PRESSED;
            tick_d[n]  = 1'b0;
          end
        end
        kpq_pkg::PH_PRESSED: begin
          phase_d[n] = kpq_pkg::PH_HELD;
          tick_d[n]  = 1'b0;
        end
        kpq_pkg::PH_HELD: begin
          if (!keys_i[n]) begin
            phase_d[n] = kpq_pkg::PH_HOLDOFF;
            tick_d[n]  = 1'b0;
          end
        end
        kpq_pkg::PH_HOLDOFF: begin
          // The holdoff lasts two ticks; the second one returns to idle.
          if (tick_q[n]) begin
            phase_d[n] = kpq_pkg::PH_IDLE;
            tick_d[n]  = 1'b0;
          end else begin
            tick_d[n] = 1'b1;
          end
        end
        default: begin
          phase_d[n] = kpq_pkg::PH_IDLE;
          tick_d[n]  = 1'b0;
        end
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q[n] <= kpq_pkg::PH_IDLE;
        tick_q[n]  <= 1'b0;
      end else if (adv_i) begin
        phase_q[n] <= phase_d[n];
        tick_q[n]  <= tick_d[n];
      end
    end

    assign press_o[n] = (phase_d[n] == kpq_pkg::PH_PRESSED);
  end

endmodule

/* rtl/core/kpq_direction.sv */
// Eight-way direction encoder with change detection against the last code.
`timescale 1ns / 1ps

module kpq_direction (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [3:0]        dir_keys_i,
  output kpq_pkg::dir_res_t res_o
);

  logic signed [3:0] prev_q;
  logic signed [3:0] code;
  logic up, rt, dn, lf;

  assign up = dir_keys_i[0];
  assign rt = dir_keys_i[1];
  assign dn = dir_keys_i[2];
  assign lf = dir_keys_i[3];

  // Later single keys win, then diagonals override in clockwise order.
  always_comb begin
    code = kpq_pkg::DirNone;
    if (up) code = kpq_pkg::DirUp;
    if (rt) code = kpq_pkg::DirRight;
    if (dn) code = kpq_pkg::DirDown;
    if (lf) code = kpq_pkg::DirLeft;
    if (up && rt) code = kpq_pkg::DirUpRight;
    if (rt && dn) code = kpq_pkg::DirDownRight;
    if (dn && lf) code = kpq_pkg::DirDownLeft;
    if (lf && up) code = kpq_pkg::DirUpLeft;
  end

  always_comb begin
    res_o.code = code;
    if (code == prev_q) begin
      res_o.event_kind = kpq_pkg::EV_SAME;
    end else if (code == kpq_pkg::DirNone) begin
      res_o.event_kind = kpq_pkg::EV_NONE;
    end else begin
      res_o.event_kind = kpq_pkg::EV_NEW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= kpq_pkg::DirNone;
    end else if (adv_i) begin
      prev_q <= code;
    end
  end

endmodule

/* rtl/core/keypad_press_qualifier_dpad_core.sv */
// Top level of the keypad press qualifier with eight-way direction pad.
// Each input transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while the result is not stalled; all eight qualifiers and the direction
// encoder update together in the single logic stage between the two registers.
// Reset: asynchronous, active low; all buttons idle, previous direction none,
// both register stages empty.
`timescale 1ns / 1ps

module keypad_press_qualifier_dpad_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kpq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output kpq_pkg::out_t  out_data_o
);

  logic              s1_valid_q;
  kpq_pkg::in_t      s1_data_q;
  logic              out_valid_q;
  logic              out_valid_d;
  kpq_pkg::out_t     out_data_q;
  logic              s1_adv;
  logic              in_fire;
  logic [7:0]        press;
  kpq_pkg::dir_res_t dir_res;
  kpq_pkg::out_t     res;

  // The input stage moves on whenever the result register is empty or being drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
  end

  kpq_qualifier u_qualifier (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s1_adv),
    .keys_i  (s1_data_q.button_keys),
    .press_o (press)
  );

  kpq_direction u_direction (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (s1_adv),
    .dir_keys_i (s1_data_q.direction_keys),
    .res_o      (dir_res)
  );

  always_comb begin
    res.virtual_buttons = {s1_data_q.enter_key,
                           press[1],
                           press[0],
                           press[2] | press[7],
                           s1_data_q.alt_fire_key,
                           press[5] | press[6],
                           press[3] | press[4]};
    res.direction_code  = dir_res.code;
    res.direction_event = dir_res.event_kind;
    res.quit_request    = s1_data_q.escape_key;
  end

  always_comb begin
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("input stage dropped a transaction while the result was blocked");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stage empty but not ready");

  a_new_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.direction_event == kpq_pkg::EV_NEW
      |-> out_data_o.direction_code != kpq_pkg::DirNone)
    else $error("new direction event without a direction");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.direction_code >= kpq_pkg::DirNone)
    else $error("direction code out of range");
`endif

endmodule

/* tb/keypad_press_qualifier_dpad_core_test.sv */
// Self-checking testbench for the keypad press qualifier with eight-way direction pad.
`timescale 1ns / 1ps

module keypad_press_qualifier_dpad_core_test;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldStretch = 300;
  localparam int unsigned PhaseItems  = 380;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  kpq_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  kpq_pkg::out_t out_data_o;

  keypad_press_qualifier_dpad_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Mirror of the qualifier state inside the block.
  kpq_pkg::phase_e   qual_phase [kpq_pkg::NumButtons];
  logic [1:0]        qual_ticks [kpq_pkg::NumButtons];
  logic signed [3:0] last_dir = kpq_pkg::DirNone;

  kpq_pkg::in_t  pending_keys [$];
  kpq_pkg::out_t expected_results [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        pressure_on = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  // Raw key levels carried over between random ticks so that presses last.
  logic [7:0] held_buttons = '0;
  logic [3:0] held_dirs = '0;

  initial begin
    for (int n = 0; n < kpq_pkg::NumButtons; n++) begin
      qual_phase[n] = kpq_pkg::PH_IDLE;
      qual_ticks[n] = '0;
    end
  end

  function automatic logic signed [3:0] encode_dpad(logic [3:0] d);
    logic signed [3:0] code;
    code = kpq_pkg::DirNone;
    if (d[0]) code = kpq_pkg::DirUp;
    if (d[1]) code = kpq_pkg::DirRight;
    if (d[2]) code = kpq_pkg::DirDown;
    if (d[3]) code = kpq_pkg::DirLeft;
    if (d[0] && d[1]) code = kpq_pkg::DirUpRight;
    if (d[1] && d[2]) code = kpq_pkg::DirDownRight;
    if (d[2] && d[3]) code = kpq_pkg::DirDownLeft;
    if (d[3] && d[0]) code = kpq_pkg::DirUpLeft;
    return code;
  endfunction

  // Advances the qualifier state by one tick and returns the result it yields.
  function automatic kpq_pkg::out_t qualify_tick(kpq_pkg::in_t item);
    logic [7:0]        pressed;
    logic signed [3:0] code;
    kpq_pkg::out_t     res;
    pressed = '0;
    for (int n = 0; n < kpq_pkg::NumButtons; n++) begin
      case (qual_phase[n])
        kpq_pkg::PH_IDLE: begin
          if (item.button_keys[n]) begin
            qual_phase[n] = kpq_pkg::PH_PRESSED;
            qual_ticks[n] = '0;
          end
        end
        kpq_pkg::PH_PRESSED: begin
          qual_phase[n] = kpq_pkg::PH_HELD;
          qual_ticks[n] = '0;
        end
        kpq_pkg::PH_HELD: begin
          if (!item.button_keys[n]) begin
            qual_phase[n] = kpq_pkg::PH_HOLDOFF;
            qual_ticks[n] = '0;
          end
        end
        default: begin
          qual_ticks[n] = qual_ticks[n] + 2'd1;
          if (qual_ticks[n] > 2'd1) begin
            qual_phase[n] = kpq_pkg::PH_IDLE;
            qual_ticks[n] = '0;
          end
        end
      endcase
      pressed[n] = (qual_phase[n] == kpq_pkg::PH_PRESSED);
    end
    res.virtual_buttons = {item.enter_key, pressed[1], pressed[0], pressed[2] | pressed[7],
                           item.alt_fire_key, pressed[5] | pressed[6],
                           pressed[3] | pressed[4]};
    code = encode_dpad(item.direction_keys);
    res.direction_code = code;
    if (code != last_dir) begin
      res.direction_event = (code != kpq_pkg::DirNone) ? kpq_pkg::EV_NEW : kpq_pkg::EV_NONE;
    end else begin
      res.direction_event = kpq_pkg::EV_SAME;
    end
    last_dir = code;
    res.quit_request = item.escape_key;
    return res;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Input side: offer queued ticks, predicting each one as it is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(qualify_tick(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_keys.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_keys.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: the long hold-off lets the block fill up and stall its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cycles <= 0;
    end else if (pressure_on && hold_cycles < HoldStretch) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      if (!pressure_on) hold_cycles <= 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none actual %h", $time, out_data_o);
      end else begin
        kpq_pkg::out_t want;
        want = expected_results.pop_front();
        compare_field("virtual_buttons", want.virtual_buttons, out_data_o.virtual_buttons);
        compare_field("direction_code", want.direction_code, out_data_o.direction_code);
        compare_field("direction_event", want.direction_event, out_data_o.direction_event);
        compare_field("quit_request", want.quit_request, out_data_o.quit_request);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL keypad_press_qualifier_dpad_core");
      $finish;
    end
  end

  task automatic push_keys(logic [7:0] buttons, logic [3:0] dirs, logic enter, logic alt,
                           logic esc);
    kpq_pkg::in_t item;
    item.button_keys    = buttons;
    item.direction_keys = dirs;
    item.enter_key      = enter;
    item.alt_fire_key   = alt;
    item.escape_key     = esc;
    pending_keys.push_back(item);
  endtask

  // Mostly persistent key levels so buttons go through press, hold and holdoff;
  // one tick in ten is pure noise.
  task automatic push_random_keys(int unsigned count);
    logic [7:0] flips;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        push_keys(8'($urandom_range(255)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        flips = '0;
        for (int n = 0; n < kpq_pkg::NumButtons; n++) flips[n] = ($urandom_range(5) == 0);
        held_buttons = held_buttons ^ flips;
        if ($urandom_range(3) == 0) held_dirs = 4'($urandom_range(15));
        push_keys(held_buttons, held_dirs, $urandom_range(3) == 0, $urandom_range(3) == 0,
                  $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic drain;
    while (pending_keys.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0, 0);

    // No direction right after reset counts as unchanged.
    push_keys(8'h00, 4'h0, 1'b0, 1'b0, 1'b0);
    push_keys(8'h00, 4'h0, 1'b0, 1'b0, 1'b0);
    // Every button pressed at once, then released while still in the pressed phase.
    push_keys(8'hFF, 4'h1, 1'b1, 1'b1, 1'b1);
    push_keys(8'h00, 4'h1, 1'b0, 1'b0, 1'b0);
    push_keys(8'h00, 4'h1, 1'b1, 1'b0, 1'b1);
    // Keys held during the release holdoff are ignored until it runs out.
    push_keys(8'hFF, 4'h0, 1'b0, 1'b1, 1'b0);
    push_keys(8'hFF, 4'h0, 1'b0, 1'b0, 1'b0);
    push_keys(8'hFF, 4'h2, 1'b1, 1'b1, 1'b1);
    push_keys(8'hFF, 4'h2, 1'b0, 1'b0, 1'b0);
    push_keys(8'hFF, 4'h2, 1'b0, 1'b0, 1'b0);
    // The remaining combinations of direction keys, all four held giving up-left.
    for (int d = 3; d < 16; d++) begin
      push_keys((d % 2) ? 8'h55 : 8'hAA, d[3:0], d[0], d[1], d[2]);
    end
    drain();

    set_idling(0, 0);
    push_random_keys(PhaseItems);
    drain();
    set_idling(61, 0);
    push_random_keys(PhaseItems);
    drain();
    set_idling(0, 61);
    push_random_keys(PhaseItems);
    drain();
    set_idling(20, 20);
    push_random_keys(PhaseItems);
    drain();

    set_idling(0, 0);
    pressure_on = 1'b1;
    push_random_keys(40);
    drain();
    pressure_on = 1'b0;

    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS keypad_press_qualifier_dpad_core");
    end else begin
      $display("FAIL keypad_press_qualifier_dpad_core");
    end
    $finish;
  end

endmodule
